// ===== hdl/utc_pkg.sv =====
// utc_pkg: shared types, constants and table functions for the unix time to
// calendar converter. Used by utc_ctrl, utc_dp and the top level.
// No dependencies.
package utc_pkg;

    localparam logic [31:0] EPOCH_RESET   = 32'd946684800;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
    localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
    // reciprocals rounded up, taken with a right shift of 37 and 36
    localparam logic [31:0] RECIP_60      = 32'h8888_8889;
    localparam logic [31:0] RECIP_24      = 32'hAAAA_AAAB;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;
    localparam logic [11:0] BASE_YEAR     = 12'd2000;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [3:0]  MONTH_MAR     = 4'd3;
    localparam int          TDATA_W       = 48;

    // which quantity the shared divider is splitting off
    localparam logic [1:0] DIV_SEC  = 2'd0;
    localparam logic [1:0] DIV_MIN  = 2'd1;
    localparam logic [1:0] DIV_HOUR = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic [1:0] div_sel;
        logic       div_capture;
        logic       quad_step;
        logic       year_step;
        logic       mon_step;
        logic       wsum_load;
        logic       out_load;
    } utc_cmd_t;

    typedef struct packed {
        logic before_epoch;
        logic quad_ge;
        logic year_ge;
        logic mon_ge;
    } utc_stat_t;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // month offsets of the weekday formula
    function automatic logic [2:0] sak_term(input logic [3:0] mon);
        logic [2:0] v;
        case (mon)
            4'd2:    v = 3'd3;
            4'd3:    v = 3'd2;
            4'd4:    v = 3'd5;
            4'd5:    v = 3'd0;
            4'd6:    v = 3'd3;
            4'd7:    v = 3'd5;
            4'd8:    v = 3'd1;
            4'd9:    v = 3'd4;
            4'd10:   v = 3'd6;
            4'd11:   v = 3'd2;
            4'd12:   v = 3'd4;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/utc_ctrl.sv =====
// utc_ctrl: sequencer for the converter; steps the shared divider, the
// year and month walks and the output register handshake.
// Depends on utc_pkg.
module utc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  utc_pkg::utc_stat_t stat,
    output utc_pkg::utc_cmd_t  cmd
);
    import utc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_DIVEND = 4'd3;
    localparam logic [3:0] S_QUAD   = 4'd4;
    localparam logic [3:0] S_YEAR   = 4'd5;
    localparam logic [3:0] S_MON    = 4'd6;
    localparam logic [3:0] S_WSUM   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.div_sel  = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load     = 1'b1;
                    phase_next   = DIV_SEC;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
                state_next = stat.before_epoch ? S_OUT : S_DIV;
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_DIVEND;
            end
            S_DIVEND:
            begin
                cmd.div_capture = 1'b1;
                if (phase_reg == DIV_HOUR)
                    state_next = S_QUAD;
                else
                begin
                    phase_next = phase_reg + 2'd1;
                    state_next = S_DIV;
                end
            end
            S_QUAD:
            begin
                if (stat.quad_ge)
                    cmd.quad_step = 1'b1;
                else
                    state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (stat.year_ge)
                    cmd.year_step = 1'b1;
                else
                    state_next = S_MON;
            end
            S_MON:
            begin
                if (stat.mon_ge)
                    cmd.mon_step = 1'b1;
                else
                    state_next = S_WSUM;
            end
            S_WSUM:
            begin
                cmd.wsum_load = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= DIV_SEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/utc_dp.sv =====
// utc_dp: datapath of the converter; epoch register, reciprocal divider,
// year and month walk, weekday sum and output register.
// Depends on utc_pkg.
module utc_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [31:0]                  unix_time,
    input  logic                         cfg_wr_en,
    input  logic [31:0]                  cfg_wr_data,
    input  utc_pkg::utc_cmd_t            cmd,
    output utc_pkg::utc_stat_t           stat,
    output logic [utc_pkg::TDATA_W-1:0]  out_tdata,
    output logic                         out_tuser
);
    import utc_pkg::*;

    logic [31:0] epoch_reg;
    logic [31:0] q_reg;
    logic [31:0] quo_reg;
    logic [5:0]  sec_reg, min_reg;
    logic [4:0]  hr_reg;
    logic [15:0] days_reg;
    logic [7:0]  yc_reg;
    logic [3:0]  mon_reg;
    logic        before_reg;
    logic [11:0] wsum_reg;
    logic [TDATA_W-1:0] tdata_reg;
    logic        tuser_reg;

    logic [32:0] diff;
    logic [5:0]  divisor;
    logic [31:0] recip;
    logic [63:0] prod;
    logic [31:0] quo_next;
    logic [5:0]  quo_mul;
    logic [5:0]  rem;
    logic        leap;
    logic [15:0] year_len;
    logic [4:0]  mlen;
    logic [4:0]  day;
    logic [11:0] y_full, y_adj, c100, c400, wsum_next;
    logic [4:0]  f1;
    logic [3:0]  f2;
    logic [2:0]  rem7, weekday;

    assign diff = {1'b0, unix_time} - {1'b0, epoch_reg};

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SEC:
            begin
                divisor = SECS_PER_MIN;
                recip   = RECIP_60;
            end
            DIV_MIN:
            begin
                divisor = MINS_PER_HOUR;
                recip   = RECIP_60;
            end
            default:
            begin
                divisor = HOURS_PER_DAY;
                recip   = RECIP_24;
            end
        endcase
    end

    // 32 x 32 product, the rounded-up reciprocal is exact for every 32-bit dividend
    assign prod     = 64'(q_reg) * 64'(recip);
    assign quo_next = (cmd.div_sel == DIV_HOUR) ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};

    // remainder is below 64, so six low bits of the product are enough
    assign quo_mul = quo_reg[5:0] * divisor;
    assign rem     = q_reg[5:0] - quo_mul;

    assign leap     = (yc_reg[1:0] == 2'b00);
    assign year_len = DAYS_PER_YEAR + {15'd0, leap};
    assign mlen     = month_len(mon_reg, leap);
    assign day      = days_reg[4:0] + 5'd1;

    assign stat.before_epoch = before_reg;
    assign stat.quad_ge      = (days_reg >= DAYS_PER_QUAD);
    assign stat.year_ge      = (days_reg >= year_len);
    assign stat.mon_ge       = (days_reg >= {11'd0, mlen}) && (mon_reg != MONTH_DEC);

    // weekday sum, y only spans 1999 to 2136 so the century terms are compares
    assign y_full = BASE_YEAR + {4'd0, yc_reg};
    assign y_adj  = (mon_reg < MONTH_MAR) ? (y_full - 12'd1) : y_full;
    assign c100   = (y_adj >= 12'd2100) ? 12'd21 : ((y_adj >= 12'd2000) ? 12'd20 : 12'd19);
    assign c400   = (y_adj >= 12'd2000) ? 12'd5 : 12'd4;
    assign wsum_next = y_adj + {2'd0, y_adj[11:2]} - c100 + c400
                     + {9'd0, sak_term(mon_reg)} + {7'd0, day};

    // mod 7 by folding octal digits, since 8 is 1 mod 7
    assign f1 = {2'd0, wsum_reg[2:0]} + {2'd0, wsum_reg[5:3]}
              + {2'd0, wsum_reg[8:6]} + {2'd0, wsum_reg[11:9]};
    assign f2 = {1'b0, f1[2:0]} + {2'd0, f1[4:3]};
    assign rem7    = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    assign weekday = (rem7 == 3'd0) ? 3'd7 : rem7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epoch_reg <= EPOCH_RESET;
        else if (cfg_wr_en)
            epoch_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg      <= diff[31:0];
            before_reg <= diff[32];
            yc_reg     <= '0;
            mon_reg    <= 4'd1;
        end
        if (cmd.div_step)
            quo_reg <= quo_next;
        if (cmd.div_capture)
        begin
            q_reg <= quo_reg;
            case (cmd.div_sel)
                DIV_SEC: sec_reg <= rem;
                DIV_MIN: min_reg <= rem;
                default:
                begin
                    hr_reg   <= rem[4:0];
                    days_reg <= quo_reg[15:0];
                end
            endcase
        end
        if (cmd.quad_step)
        begin
            days_reg <= days_reg - DAYS_PER_QUAD;
            yc_reg   <= yc_reg + 8'd4;
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - year_len;
            yc_reg   <= yc_reg + 8'd1;
        end
        if (cmd.mon_step)
        begin
            days_reg <= days_reg - {11'd0, mlen};
            mon_reg  <= mon_reg + 4'd1;
        end
        if (cmd.wsum_load)
            wsum_reg <= wsum_next;
        if (cmd.out_load)
        begin
            tuser_reg <= before_reg;
            if (before_reg)
                tdata_reg <= '0;
            else
                tdata_reg <= {7'd0, weekday, sec_reg, min_reg, hr_reg, day, mon_reg, y_full};
        end
    end

    assign out_tdata = tdata_reg;
    assign out_tuser = tuser_reg;

endmodule

// ===== hdl/unix_time_to_calendar.sv =====
// unix_time_to_calendar: 32-bit unix time to date, time of day and weekday.
// Each item runs three reciprocal divide steps and the 4-year/year/month walk; an item before the epoch skips them.
// One item at a time: the next accept can come in the same cycle that m_tvalid rises.
// A finished item waits in the output register; the block stalls only while it is unread.
// rst_n is asynchronous, active low; epoch_offset resets to 946684800.
module unix_time_to_calendar (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [31:0]                 cfg_wr_data,  // epoch_offset
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,      // unix_time
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26]
    // second[37:32] weekday[40:38] zero[47:41]
    output logic [utc_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser       // before_epoch
);
    import utc_pkg::*;

    utc_cmd_t  cmd;
    utc_stat_t stat;

    utc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    utc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .unix_time   (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_tdata   (m_tdata),
        .out_tuser   (m_tuser)
    );

endmodule

// ===== hdl/utc_checker.sv =====
// utc_checker: port-level assertions for unix_time_to_calendar, bound to
// the top level. Depends on utc_pkg.
module utc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [utc_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import utc_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // one item in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // before the epoch every field reads zero
    a_before: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("before-epoch item has nonzero fields");

    // a converted date is well formed
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12 &&
            m_tdata[20:16] != 5'd0 && m_tdata[25:21] <= 5'd23 &&
            m_tdata[40:38] != 3'd0 && m_tdata[11:0] >= BASE_YEAR)
        else $error("converted date out of range");

endmodule

bind unix_time_to_calendar utc_checker u_utc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
